FILE: rtl/ild_pkg.sv
// Shared types and byte constants for the x86-64 instruction length decoder.
`default_nettype none

package ild_pkg;

  // Field widths
  localparam int unsigned WinWidth = 64;
  localparam int unsigned LenWidth = 4;

  typedef logic [WinWidth-1:0] win_t;
  typedef logic [LenWidth-1:0] len_t;
  typedef logic [7:0]          byte_t;

  // Prefix and opcode codes
  localparam byte_t REX_LO     = 8'h40;
  localparam byte_t REX_HI     = 8'h4F;
  localparam byte_t OPSIZE_PFX = 8'h66;
  localparam byte_t ESC_0F     = 8'h0F;
  localparam byte_t LOCK_PFX   = 8'hF0;
  localparam byte_t REPNE_PFX  = 8'hF2;
  localparam byte_t REP_PFX    = 8'hF3;
  localparam byte_t MOFFS_LO   = 8'hA0;
  localparam byte_t MOFFS_HI   = 8'hA3;
  localparam byte_t CALL_REL   = 8'hE8;

  // ModRM field codes
  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;
  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] RM_RIPREL  = 3'd5;
  localparam logic [2:0] BASE_NONE  = 3'd5;

endpackage : ild_pkg

`default_nettype wire

FILE: rtl/x86_instruction_length_decoder_core.sv
// Top level of the x86-64 instruction length decoder: window register, decode, result register.
`default_nettype none

// Takes an eight-byte code window (byte 0 in bits 7:0) and returns the length of the
// instruction that starts at byte 0, with decodable set when the length is nonzero.
// An accepted window lands in an input register; the table decode runs combinationally
// between it and the result register, which holds the result offered on len_valid. A new window
// is taken every cycle while code_stall is low. code_stall rises only when both
// registers hold data and the result side is stalled.
module x86_instruction_length_decoder_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          code_valid,
  output logic          code_stall,
  input  ild_pkg::win_t code_window,
  output logic          len_valid,
  input  logic          len_stall,
  output ild_pkg::len_t instr_length,
  output logic          decodable
);
  import ild_pkg::*;

  logic win_valid;
  win_t window;
  len_t dec_len;
  logic res_open;
  logic win_open;

  // Result register can load when empty or being drained; window likewise
  assign res_open   = !len_valid || !len_stall;
  assign win_open   = !win_valid || res_open;
  assign code_stall = !win_open;

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (win_open) begin
      win_valid <= code_valid;
    end
    if (win_open && code_valid) begin
      window <= code_window;
    end
  end

  ild_decode u_decode (
    .window (window),
    .length (dec_len)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      len_valid <= 1'b0;
    end else if (res_open) begin
      len_valid <= win_valid;
    end
    if (res_open && win_valid) begin
      instr_length <= dec_len;
      decodable    <= (dec_len != '0);
    end
  end

endmodule : x86_instruction_length_decoder_core

`default_nettype wire

FILE: rtl/ild_decode.sv
// Combinational length decode of one registered instruction byte window.
`default_nettype none

module ild_decode (
  input  ild_pkg::win_t window,
  output ild_pkg::len_t length
);
  import ild_pkg::*;

  // Byte select; positions wrap inside the eight-byte window
  function automatic byte_t byte_at(input win_t w, input len_t pos);
    return w[{pos[2:0], 3'b000} +: 8];
  endfunction

  function automatic logic is_rex(input byte_t b);
    return (b >= REX_LO) && (b <= REX_HI);
  endfunction

  // Position just past ModRM, optional SIB and displacement
  function automatic len_t modrm_end(input win_t w, input len_t pos);
    byte_t      m;
    byte_t      sib;
    logic [1:0] md;
    logic [2:0] rm;
    len_t       p;
    m  = byte_at(w, pos);
    md = m[7:6];
    rm = m[2:0];
    p  = pos + len_t'(1);
    if (md == MOD_REG) return p;
    if (rm == RM_SIB) begin
      sib = byte_at(w, p);
      p   = p + len_t'(1);
      if (sib[2:0] == BASE_NONE && md == MOD_NODISP) p = p + len_t'(4);
    end
    if (md == MOD_NODISP && rm == RM_RIPREL) p = p + len_t'(4);
    else if (md == MOD_DISP8)                p = p + len_t'(1);
    else if (md == MOD_DISP32)               p = p + len_t'(4);
    return p;
  endfunction

  // 0F two-byte opcode table
  function automatic len_t two_byte(input win_t w, input len_t pos);
    byte_t op;
    len_t  p;
    op = byte_at(w, pos);
    p  = pos + len_t'(1);
    if (op inside {8'h05, 8'h0B, 8'h31})   return p;
    if (op inside {[8'h70:8'h7F]})         return p + len_t'(1);
    if (op inside {[8'h80:8'h8F]})         return p + len_t'(4);
    if (op inside {[8'hA0:8'hA3]})         return p + len_t'(1);
    if (op inside {[8'h40:8'h4F], [8'h90:8'h9F], 8'hAF, 8'hB6, 8'hB7, 8'hBE,
                   8'hBF, 8'hC0, 8'hC1, [8'h10:8'h1F], 8'h28, 8'h29, 8'h2E,
                   8'h2F, [8'h50:8'h6F]})
      return modrm_end(w, p);
    return '0;
  endfunction

  byte_t op;
  byte_t nx_66;
  byte_t nx_lock;
  byte_t nx_rep;
  byte_t nb_rep;
  logic  rex;
  len_t  pos;
  len_t  pos_66;
  len_t  pos_lock;
  len_t  len_66;
  len_t  len_lock;
  len_t  len_repne;
  len_t  len_rep;
  len_t  len;

  // Prefix paths evaluated side by side, then picked by the opcode
  always_comb begin
    rex = is_rex(byte_at(window, len_t'(0)));
    pos = rex ? len_t'(1) : len_t'(0);
    op  = byte_at(window, pos);
    pos = pos + len_t'(1);

    // Operand size prefix, with an optional REX after it
    pos_66 = pos;
    if (is_rex(byte_at(window, pos_66))) pos_66 = pos_66 + len_t'(1);
    nx_66  = byte_at(window, pos_66);
    pos_66 = pos_66 + len_t'(1);
    if (nx_66 == 8'h05)                len_66 = pos_66;
    else if (nx_66 == ESC_0F)          len_66 = modrm_end(window, pos_66 + len_t'(1));
    else if (nx_66 inside {8'hC1, 8'hD5})
      len_66 = modrm_end(window, pos_66) + len_t'(1);
    else                               len_66 = modrm_end(window, pos_66);

    // Lock prefix skips the escape plus opcode, or a listed opcode
    nx_lock  = byte_at(window, pos);
    pos_lock = pos;
    if (nx_lock == ESC_0F) pos_lock = pos + len_t'(2);
    else if (nx_lock inside {8'h44, 8'h45, [8'h80:8'h83], [8'h90:8'h93], 8'hA0, 8'hA1,
                             8'hA3, 8'hC0, 8'hC1})
      pos_lock = pos + len_t'(1);
    len_lock = modrm_end(window, pos_lock);

    // REPNE / REP with the 0F escape
    nb_rep = byte_at(window, pos);
    nx_rep = byte_at(window, pos + len_t'(1));
    if (nb_rep != ESC_0F) len_repne = modrm_end(window, pos);
    else if (nx_rep inside {[8'h10:8'h13], 8'h2A, 8'h2B, 8'h51, 8'h58, 8'h59,
                            [8'h5C:8'h5F]})
      len_repne = modrm_end(window, pos + len_t'(2));
    else len_repne = '0;
    if (nb_rep != ESC_0F) len_rep = modrm_end(window, pos);
    else if (nx_rep inside {[8'h10:8'h13], 8'h1E, 8'h6E, 8'h6F, 8'h7E, 8'h7F})
      len_rep = modrm_end(window, pos + len_t'(2));
    else len_rep = '0;

    // One-byte opcode table
    if (op inside {[8'h50:8'h5F]})                    len = pos;
    else if (op inside {[8'h70:8'h7F]})               len = pos + len_t'(1);
    else if (op inside {[8'hB0:8'hB7]})               len = pos + len_t'(1);
    else if (op inside {[8'hB8:8'hBF]})               len = pos + len_t'(4);
    else if (op inside {[8'hD0:8'hDF]})               len = modrm_end(window, pos);
    else if (op inside {[MOFFS_LO:MOFFS_HI]})
      len = pos + (rex ? len_t'(8) : len_t'(4));
    else if (op inside {[8'h84:8'h8B], 8'h8D})        len = modrm_end(window, pos);
    else if (op inside {8'h60, 8'h61, 8'h90, 8'hC3, 8'hCC}) len = pos;
    else if (op inside {8'h63, 8'hF6, 8'hF7, 8'hFE, 8'hFF})
      len = modrm_end(window, pos);
    else if (op inside {8'h68, 8'hA9, CALL_REL, 8'hE9}) len = pos + len_t'(4);
    else if (op inside {8'h6A, 8'hA8, 8'hEB})         len = pos + len_t'(1);
    else if (op inside {8'hC2, 8'hCD})                len = pos + len_t'(2);
    else if (op == 8'hC8)                             len = pos + len_t'(3);
    else if (op inside {8'h69, 8'h81, 8'hC7})
      len = modrm_end(window, pos) + len_t'(4);
    else if (op inside {8'h6B, 8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6})
      len = modrm_end(window, pos) + len_t'(1);
    else if (op == ESC_0F)                            len = two_byte(window, pos);
    else if (op == OPSIZE_PFX)                        len = len_66;
    else if (op == LOCK_PFX)                          len = len_lock;
    else if (op == REPNE_PFX)                         len = len_repne;
    else if (op == REP_PFX)                           len = len_rep;
    else                                              len = '0;
  end

  assign length = len;

endmodule : ild_decode

`default_nettype wire

FILE: tb/sv/x86_instruction_length_decoder_core_tb.sv
// Self-checking testbench for the x86-64 instruction length decoder core.
`default_nettype none

module x86_instruction_length_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ild_pkg::*;

  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned PhaseItems  = 108;

  typedef struct packed {
    win_t  window;
    len_t  length;
    logic  decodable;
  } length_result_t;

  // Predicts the decoded length of each accepted window and checks results in order
  class length_checker;
    length_result_t expected_lengths[$];
    int unsigned    n_errors;

    function byte_t byte_of(win_t w, int unsigned i);
      return w[8*(i%8) +: 8];
    endfunction

    function logic is_rex(byte_t b);
      return b >= REX_LO && b <= REX_HI;
    endfunction

    // pos points at the ModRM byte; returns the position after ModRM, SIB and displacement
    function int unsigned modrm_end(win_t w, int unsigned pos);
      byte_t       m;
      byte_t       sib;
      int unsigned p;
      m = byte_of(w, pos);
      p = pos + 1;
      if (m[7:6] == MOD_REG) return p;
      if (m[2:0] == RM_SIB) begin
        sib = byte_of(w, p);
        p++;
        if (sib[2:0] == BASE_NONE && m[7:6] == MOD_NODISP) p += 4;
      end
      if (m[7:6] == MOD_NODISP && m[2:0] == RM_RIPREL) p += 4;
      else if (m[7:6] == MOD_DISP8) p += 1;
      else if (m[7:6] == MOD_DISP32) p += 4;
      return p;
    endfunction

    // 0F escape table
    function int unsigned two_byte_end(win_t w, int unsigned pos);
      byte_t op;
      op = byte_of(w, pos);
      pos++;
      if (op == 8'h05 || op == 8'h0B || op == 8'h31) return pos;
      if (op >= 8'h70 && op <= 8'h7F) return pos + 1;
      if (op >= 8'h80 && op <= 8'h8F) return pos + 4;
      if (op >= 8'hA0 && op <= 8'hA3) return pos + 1;
      if ((op >= 8'h40 && op <= 8'h4F) || (op >= 8'h90 && op <= 8'h9F) ||
          op == 8'hAF || op == 8'hB6 || op == 8'hB7 || op == 8'hBE ||
          op == 8'hBF || op == 8'hC0 || op == 8'hC1 ||
          (op >= 8'h10 && op <= 8'h1F) || op == 8'h28 || op == 8'h29 ||
          op == 8'h2E || op == 8'h2F || (op >= 8'h50 && op <= 8'h6F))
        return modrm_end(w, pos);
      return 0;
    endfunction

    function int unsigned window_length(win_t w);
      int unsigned pos;
      logic        rex;
      byte_t       op;
      byte_t       nx;
      pos = 0;
      rex = 1'b0;
      if (is_rex(byte_of(w, 0))) begin
        rex = 1'b1;
        pos = 1;
      end
      op = byte_of(w, pos);
      pos++;

      // opcode ranges first
      if (op >= 8'h50 && op <= 8'h5F) return pos;
      if (op >= 8'h70 && op <= 8'h7F) return pos + 1;
      if (op >= 8'hB0 && op <= 8'hB7) return pos + 1;
      if (op >= 8'hB8 && op <= 8'hBF) return pos + 4;
      if (op >= 8'hD0 && op <= 8'hDF) return modrm_end(w, pos);
      if (op >= MOFFS_LO && op <= MOFFS_HI) return pos + (rex ? 8 : 4);
      if ((op >= 8'h84 && op <= 8'h8B) || op == 8'h8D) return modrm_end(w, pos);

      case (op)
        8'h60, 8'h61, 8'h90, 8'hC3, 8'hCC: return pos;
        8'h63, 8'hF6, 8'hF7, 8'hFE, 8'hFF: return modrm_end(w, pos);
        8'h68, 8'hA9, CALL_REL, 8'hE9: return pos + 4;
        8'h6A, 8'hA8, 8'hEB: return pos + 1;
        8'hC2, 8'hCD: return pos + 2;
        8'hC8: return pos + 3;
        8'h69, 8'h81, 8'hC7: return modrm_end(w, pos) + 4;
        8'h6B, 8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6: return modrm_end(w, pos) + 1;
        ESC_0F: return two_byte_end(w, pos);
        OPSIZE_PFX: begin
          // a REX right after 0x66 is skipped too
          if (is_rex(byte_of(w, pos))) pos++;
          nx = byte_of(w, pos);
          pos++;
          if (nx == 8'h05) return pos;
          if (nx == ESC_0F) return modrm_end(w, pos + 1);
          if (nx == 8'hC1 || nx == 8'hD5) return modrm_end(w, pos) + 1;
          return modrm_end(w, pos);
        end
        LOCK_PFX: begin
          nx = byte_of(w, pos);
          if (nx == ESC_0F) pos += 2;
          else if (nx == 8'h44 || nx == 8'h45 || (nx >= 8'h80 && nx <= 8'h83) ||
                   (nx >= 8'h90 && nx <= 8'h93) || nx == 8'hA0 || nx == 8'hA1 ||
                   nx == 8'hA3 || nx == 8'hC0 || nx == 8'hC1) pos += 1;
          return modrm_end(w, pos);
        end
        REPNE_PFX: begin
          if (byte_of(w, pos) != ESC_0F) return modrm_end(w, pos);
          nx = byte_of(w, pos + 1);
          pos += 2;
          if ((nx >= 8'h10 && nx <= 8'h13) || nx == 8'h2A || nx == 8'h2B ||
              nx == 8'h51 || nx == 8'h58 || nx == 8'h59 ||
              (nx >= 8'h5C && nx <= 8'h5F))
            return modrm_end(w, pos);
          return 0;
        end
        REP_PFX: begin
          if (byte_of(w, pos) != ESC_0F) return modrm_end(w, pos);
          nx = byte_of(w, pos + 1);
          pos += 2;
          if ((nx >= 8'h10 && nx <= 8'h13) || nx == 8'h1E || nx == 8'h6E ||
              nx == 8'h6F || nx == 8'h7E || nx == 8'h7F)
            return modrm_end(w, pos);
          return 0;
        end
        default: return 0;
      endcase
    endfunction

    function void note_window(win_t w);
      length_result_t r;
      int unsigned    n;
      n = window_length(w);
      r.window    = w;
      r.length    = len_t'(n);
      r.decodable = (n != 0);
      expected_lengths.insert(expected_lengths.size(), r);
    endfunction

    function void check_result(len_t length, logic decodable);
      length_result_t r;
      if (expected_lengths.size() == 0) begin
        $display("%0t: unexpected result length %0d decodable %0b", $time, length, decodable);
        n_errors++;
        return;
      end
      r = expected_lengths.pop_front();
      if (length !== r.length) begin
        $display("%0t: window %h instr_length expected %0d actual %0d",
                 $time, r.window, r.length, length);
        n_errors++;
      end
      if (decodable !== r.decodable) begin
        $display("%0t: window %h decodable expected %0b actual %0b",
                 $time, r.window, r.decodable, decodable);
        n_errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic code_valid;
  logic code_stall;
  win_t code_window;
  logic len_valid;
  logic len_stall = 1'b0;
  len_t instr_length;
  logic decodable;

  length_checker lengths = new;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_reqs;
  int unsigned holds_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles;

  // Opcode pools that steer random windows into the decode tables
  byte_t one_ops[$] = '{8'h50, 8'h5F, 8'h70, 8'h7F, 8'hB0, 8'hB7, 8'hB8, 8'hBF, 8'hD0,
                        8'hDF, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'h84, 8'h8B, 8'h8D, 8'h60,
                        8'h61, 8'h90, 8'hC3, 8'hCC, 8'h63, 8'hF6, 8'hF7, 8'hFE, 8'hFF,
                        8'h68, 8'hA9, 8'hE8, 8'hE9, 8'h6A, 8'hA8, 8'hEB, 8'hC2, 8'hCD,
                        8'hC8, 8'h69, 8'h81, 8'hC7, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hC0,
                        8'hC1, 8'hC6, 8'h0F, 8'h66, 8'hF0, 8'hF2, 8'hF3};
  byte_t two_ops[$] = '{8'h05, 8'h0B, 8'h31, 8'h70, 8'h7F, 8'h80, 8'h8F, 8'hA0, 8'hA3,
                        8'h40, 8'h4F, 8'h90, 8'h9F, 8'hAF, 8'hB6, 8'hB7, 8'hBE, 8'hBF,
                        8'hC0, 8'hC1, 8'h10, 8'h1F, 8'h28, 8'h29, 8'h2E, 8'h2F, 8'h50,
                        8'h6F, 8'hFF};
  byte_t opsize_next[$] = '{8'h05, 8'h0F, 8'hC1, 8'hD5, 8'h8B, 8'h89};
  byte_t lock_next[$]   = '{8'h0F, 8'h44, 8'h45, 8'h80, 8'h83, 8'h90, 8'h93, 8'hA0,
                            8'hA1, 8'hA3, 8'hC0, 8'hC1, 8'h01, 8'hFF};
  byte_t repne_ops[$]   = '{8'h10, 8'h13, 8'h2A, 8'h2B, 8'h51, 8'h58, 8'h59, 8'h5C,
                            8'h5F, 8'h00};
  byte_t rep_ops[$]     = '{8'h10, 8'h13, 8'h1E, 8'h6E, 8'h6F, 8'h7E, 8'h7F, 8'hFF};

  // Hand-picked windows: extremes, each prefix path, each addressing form
  win_t directed_windows[$] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0050,
    64'h0000_1234_5678_B848, 64'h1122_3344_5566_A148, 64'h0000_0044_3322_11A1,
    64'h0000_0000_1000_00E8, 64'h0000_0010_0000_840F, 64'h0000_0000_0000_050F,
    64'h0000_1000_0025_048B, 64'h0000_0010_0000_058B, 64'h0000_0000_0824_448B,
    64'h0000_0010_0000_808B, 64'h0000_0000_0000_C08B, 64'h0010_0000_2504_6948,
    64'h0000_0000_C0AF_0F66, 64'h0000_00C0_AF0F_4866, 64'h0000_0000_0000_0566,
    64'h0000_0000_04E0_C166, 64'h0000_0000_0EB1_0FF0, 64'h0000_0000_0100_83F0,
    64'h0000_0000_00C0_00F0, 64'h0000_0000_C110_0FF2, 64'h0000_0000_0000_0FF2,
    64'h0000_0000_FA1E_0FF3, 64'h0000_0000_00FF_0FF3, 64'h0000_0000_0010_00C8,
    64'h0000_0000_0000_FF0F};

  x86_instruction_length_decoder_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .code_window  (code_window),
    .len_valid    (len_valid),
    .len_stall    (len_stall),
    .instr_length (instr_length),
    .decodable    (decodable)
  );

  always #5 clk = ~clk;

  function automatic byte_t pick(byte_t choices[$]);
    return choices[$urandom_range(choices.size() - 1)];
  endfunction

  // Mostly well-formed prefix/opcode sequences with random tails, some pure noise
  function automatic win_t random_window();
    win_t        w;
    int unsigned p;
    w = {$urandom, $urandom};
    case ($urandom_range(9))
      2, 3: w[7:0] = pick(one_ops);
      4: begin
        w[7:0]  = byte_t'(REX_LO + $urandom_range(15));
        w[15:8] = pick(one_ops);
      end
      5: begin
        w[7:0]  = ESC_0F;
        w[15:8] = pick(two_ops);
      end
      6: begin
        w[7:0] = OPSIZE_PFX;
        p = 1;
        if ($urandom_range(1) == 1) begin
          w[15:8] = byte_t'(REX_LO + $urandom_range(15));
          p = 2;
        end
        w[8*p +: 8] = pick(opsize_next);
      end
      7: begin
        w[7:0]  = LOCK_PFX;
        w[15:8] = pick(lock_next);
      end
      8: begin
        w[7:0] = REPNE_PFX;
        if ($urandom_range(3) != 0) w[15:8] = ESC_0F;
        w[23:16] = pick(repne_ops);
      end
      9: begin
        w[7:0] = REP_PFX;
        if ($urandom_range(3) != 0) w[15:8] = ESC_0F;
        w[23:16] = pick(rep_ops);
      end
      default: ;
    endcase
    return w;
  endfunction

  // Offer one window, with an optional random gap first; holds until transferred
  task automatic send_window(input win_t w);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      code_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    code_valid  <= 1'b1;
    code_window <= w;
    do @(posedge clk); while (code_stall);
  endtask

  // Result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      len_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_seen) begin
      holds_seen <= hold_reqs;
      hold_left  <= HoldCycles;
      len_stall  <= 1'b1;
    end else begin
      len_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (code_valid && !code_stall) lengths.note_window(code_window);
      if (len_valid && !len_stall) lengths.check_result(instr_length, decodable);
      if ((code_valid && !code_stall) || (len_valid && !len_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    code_valid  = 1'b0;
    code_window = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_reqs   = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_windows[i]) send_window(directed_windows[i]);

    // Random windows under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 81; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 81; end
        default: begin idle_pct = 34; stall_pct <= 34; end
      endcase
      repeat (PhaseItems) send_window(random_window());
    end

    // Long receiver hold-off while the sender keeps offering, so the input backs up
    idle_pct = 0;
    stall_pct <= 0;
    hold_reqs <= hold_reqs + 1;
    repeat (40) send_window(random_window());
    code_valid <= 1'b0;

    while (lengths.expected_lengths.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (lengths.n_errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule : x86_instruction_length_decoder_core_tb

`default_nettype wire
